// ===== rtl/core/rrc_pkg.sv =====
package rrc_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int PHASE_SHIFT   = 8 + FRAC_BITS;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;

  localparam logic [37:0] DEG_TO_PHASE = 38'd3054198966;
  localparam logic [37:0] RAD_TO_PHASE = 38'd174992710548;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [63:0] HALF_ROUND  = 64'sd1073741824;

  localparam logic [1:0] REG_FRONT_WIDTH   = 2'd0;
  localparam logic [1:0] REG_SIDE_LENGTH   = 2'd1;
  localparam logic [1:0] REG_ANGLE_DEGREES = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [1:0]        q;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } cell_t;

  // arctangent of 2^-i as a fraction of a turn, 2^32 per turn
  function automatic logic signed [31:0] atan_phase(input logic [4:0] i);
    logic signed [31:0] a;
    unique case (i)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10679838;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2608;
      5'd19:   a = 32'sd1304;
      5'd20:   a = 32'sd652;
      5'd21:   a = 32'sd326;
      5'd22:   a = 32'sd163;
      5'd23:   a = 32'sd81;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/rrc_phase.sv =====
module rrc_phase (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [31:0]   center_x,
  input  logic signed [31:0]   center_y,
  input  logic signed [31:0]   heading,
  input  logic                 angle_in_degrees,
  output rrc_pkg::cell_t       cell_out
);

  logic [37:0]        mul;
  logic               s0_valid;
  logic signed [63:0] p_lo;
  logic [31:0]        p_hi;
  logic signed [31:0] s0_cx;
  logic signed [31:0] s0_cy;
  logic [63:0]        prod;
  logic [31:0]        phase;
  logic [31:0]        phase_rnd;
  logic [1:0]         quad;
  logic [31:0]        resid;

  assign mul = angle_in_degrees ? rrc_pkg::DEG_TO_PHASE : rrc_pkg::RAD_TO_PHASE;

  // split the turn multiplier so that each product stays within 32 by 33 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
    if (en) begin
      p_lo  <= 64'(heading * $signed({1'b0, mul[31:0]}));
      p_hi  <= 32'(heading * $signed({1'b0, mul[37:32]}));
      s0_cx <= center_x;
      s0_cy <= center_y;
    end
  end

  assign prod      = p_lo + {p_hi, 32'd0};
  assign phase     = prod[rrc_pkg::PHASE_SHIFT + 31 -: 32];
  assign phase_rnd = phase + 32'h2000_0000;
  assign quad      = phase_rnd[31:30];
  assign resid     = phase - {quad, 30'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out.valid <= s0_valid;
    end
    if (en) begin
      cell_out.q  <= quad;
      cell_out.x  <= rrc_pkg::CORDIC_GAIN;
      cell_out.y  <= 32'sd0;
      cell_out.z  <= $signed(resid);
      cell_out.cx <= s0_cx;
      cell_out.cy <= s0_cy;
    end
  end

endmodule

// ===== rtl/core/rrc_cordic_cell.sv =====
module rrc_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rrc_pkg::cell_t cell_in,
  output rrc_pkg::cell_t cell_out
);

  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] ang;

  assign xs  = cell_in.x >>> STAGE;
  assign ys  = cell_in.y >>> STAGE;
  assign ang = rrc_pkg::atan_phase(5'(STAGE));

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out.valid <= cell_in.valid;
    end
    if (en) begin
      // rotate towards zero residual angle
      if (cell_in.z >= 0) begin
        cell_out.x <= cell_in.x - ys;
        cell_out.y <= cell_in.y + xs;
        cell_out.z <= cell_in.z - ang;
      end else begin
        cell_out.x <= cell_in.x + ys;
        cell_out.y <= cell_in.y - xs;
        cell_out.z <= cell_in.z + ang;
      end
      cell_out.q  <= cell_in.q;
      cell_out.cx <= cell_in.cx;
      cell_out.cy <= cell_in.cy;
    end
  end

endmodule

// ===== rtl/core/rrc_corner.sv =====
module rrc_corner (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  rrc_pkg::cell_t     cell_in,
  input  logic [30:0]        front_width,
  input  logic [30:0]        side_length,
  output logic               out_valid,
  output logic signed [31:0] corner_x [4],
  output logic signed [31:0] corner_y [4]
);

  logic               q_valid;
  logic signed [31:0] cosv;
  logic signed [31:0] sinv;
  logic signed [31:0] q_cx;
  logic signed [31:0] q_cy;

  logic               m_valid;
  logic signed [63:0] fc;
  logic signed [63:0] fs;
  logic signed [63:0] sc;
  logic signed [63:0] ss;
  logic signed [31:0] m_cx;
  logic signed [31:0] m_cy;

  logic               o_valid;
  logic signed [32:0] off_x [4];
  logic signed [32:0] off_y [4];
  logic signed [31:0] o_cx;
  logic signed [31:0] o_cy;

  logic signed [63:0] sum_x [4];
  logic signed [63:0] sum_y [4];

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] c,
                                                 input logic signed [32:0] o);
    logic signed [33:0] s;
    s = 34'(c) + 34'(o);
    if (s > 34'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (s < -34'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  // turn the residual result by the nearest quarter turns
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= cell_in.valid;
    end
    if (en) begin
      unique case (cell_in.q)
        2'd0: begin
          cosv <= cell_in.x;
          sinv <= cell_in.y;
        end
        2'd1: begin
          cosv <= -cell_in.y;
          sinv <= cell_in.x;
        end
        2'd2: begin
          cosv <= -cell_in.x;
          sinv <= -cell_in.y;
        end
        default: begin
          cosv <= cell_in.y;
          sinv <= -cell_in.x;
        end
      endcase
      q_cx <= cell_in.cx;
      q_cy <= cell_in.cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= q_valid;
    end
    if (en) begin
      fc   <= $signed({1'b0, front_width}) * cosv;
      fs   <= $signed({1'b0, front_width}) * sinv;
      sc   <= $signed({1'b0, side_length}) * cosv;
      ss   <= $signed({1'b0, side_length}) * sinv;
      m_cx <= q_cx;
      m_cy <= q_cy;
    end
  end

  // corner order: front-left, front-right, rear-right, rear-left
  assign sum_x[0] = -fc - ss + rrc_pkg::HALF_ROUND;
  assign sum_x[1] =  fc - ss + rrc_pkg::HALF_ROUND;
  assign sum_x[2] =  fc + ss + rrc_pkg::HALF_ROUND;
  assign sum_x[3] = -fc + ss + rrc_pkg::HALF_ROUND;
  assign sum_y[0] =  sc - fs + rrc_pkg::HALF_ROUND;
  assign sum_y[1] =  sc + fs + rrc_pkg::HALF_ROUND;
  assign sum_y[2] = -sc + fs + rrc_pkg::HALF_ROUND;
  assign sum_y[3] = -sc - fs + rrc_pkg::HALF_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= m_valid;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        off_x[k] <= sum_x[k][63:31];
        off_y[k] <= sum_y[k][63:31];
      end
      o_cx <= m_cx;
      o_cy <= m_cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= o_valid;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        corner_x[k] <= sat_add(o_cx, off_x[k]);
        corner_y[k] <= sat_add(o_cy, off_y[k]);
      end
    end
  end

endmodule

// ===== rtl/core/rotated_rectangle_corners.sv =====
// Corners of a rectangle turned about its centre. Each request carries a
// centre (signed Q16.16) and a heading in degrees or radians; the block
// returns the front-left, front-right, rear-right and rear-left corners,
// saturated to signed Q16.16. It takes one request per clock while the output is not
// stalled and answers through a pipeline: two registers turn the heading into
// a phase, one CORDIC cell per stage, then quadrant fix-up, the width and length
// products, the offset sums and the saturating add.
// A stall on a valid output freezes the whole pipeline, the result register
// holding its request, and stalls the input in the same cycle.
module rotated_rectangle_corners #(
  parameter int CORDIC_STAGES = rrc_pkg::CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] front_left_x,
  output logic signed [31:0] front_left_y,
  output logic signed [31:0] front_right_x,
  output logic signed [31:0] front_right_y,
  output logic signed [31:0] rear_right_x,
  output logic signed [31:0] rear_right_y,
  output logic signed [31:0] rear_left_x,
  output logic signed [31:0] rear_left_y
);

  localparam int NUM_CELLS = (CORDIC_STAGES < rrc_pkg::ATAN_ENTRIES) ?
                             CORDIC_STAGES : rrc_pkg::ATAN_ENTRIES;

  logic               en;
  logic [30:0]        front_width;
  logic [30:0]        side_length;
  logic               angle_in_degrees;
  rrc_pkg::cell_t     chain [NUM_CELLS + 1];
  logic signed [31:0] corner_x [4];
  logic signed [31:0] corner_y [4];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_width      <= 31'd65536;
      side_length      <= 31'd65536;
      angle_in_degrees <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rrc_pkg::REG_FRONT_WIDTH:   front_width      <= cfg_data;
        rrc_pkg::REG_SIDE_LENGTH:   side_length      <= cfg_data;
        rrc_pkg::REG_ANGLE_DEGREES: angle_in_degrees <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rrc_phase u_phase (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (in_valid),
    .center_x         (center_x),
    .center_y         (center_y),
    .heading          (heading),
    .angle_in_degrees (angle_in_degrees),
    .cell_out         (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rrc_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i + 1])
    );
  end

  rrc_corner u_corner (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cell_in     (chain[NUM_CELLS]),
    .front_width (front_width),
    .side_length (side_length),
    .out_valid   (out_valid),
    .corner_x    (corner_x),
    .corner_y    (corner_y)
  );

  assign front_left_x  = corner_x[0];
  assign front_left_y  = corner_y[0];
  assign front_right_x = corner_x[1];
  assign front_right_y = corner_y[1];
  assign rear_right_x  = corner_x[2];
  assign rear_right_y  = corner_y[2];
  assign rear_left_x   = corner_x[3];
  assign rear_left_y   = corner_y[3];

`ifndef ASSERT_OFF
  // the residual angle entering the cells lies within an eighth of a turn
  a_resid_range: assert property (@(posedge clk) disable iff (rst)
    chain[0].valid |-> (chain[0].z >= -32'sd536870912 && chain[0].z < 32'sd536870912))
    else $error("residual angle outside an eighth of a turn");

  // after the last cell the residual has converged below a quarter turn
  a_resid_conv: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_CELLS].valid |->
      (chain[NUM_CELLS].z > -32'sd1073741824 && chain[NUM_CELLS].z < 32'sd1073741824))
    else $error("CORDIC residual did not converge");

  // a frozen pipeline keeps its result on the output
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(front_left_x)
      && $stable(rear_right_y)))
    else $error("result changed while stalled");

  // nothing leaves the block straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int    DUT_LATENCY  = rrc_pkg::CORDIC_STAGES + 6;
  localparam int    CYCLE_LIMIT  = 300000;
  localparam int    ATAN_COUNT   = 24;
  localparam int    RAND_PHASES  = 8;
  localparam int    PHASE_POSES  = 154;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint ROUND_HALF  = 64'sd1073741824;
  localparam logic [63:0] PHASE_PER_DEG = 64'd3054198966;
  localparam logic [63:0] PHASE_PER_RAD = 64'd174992710548;
  localparam logic [30:0] DIM_MAX  = 31'h7FFF_FFFF;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] hd;
  } pose_t;

  // fl_x, fl_y, fr_x, fr_y, rr_x, rr_y, rl_x, rl_y from index 0 upwards
  typedef logic [7:0][31:0] corner_set_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = rrc_pkg::REG_FRONT_WIDTH;
  logic [30:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] center_x = '0;
  logic signed [31:0] center_y = '0;
  logic signed [31:0] heading = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] front_left_x, front_left_y, front_right_x, front_right_y;
  logic signed [31:0] rear_right_x, rear_right_y, rear_left_x, rear_left_y;

  rotated_rectangle_corners dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .center_x(center_x), .center_y(center_y), .heading(heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .front_left_x(front_left_x), .front_left_y(front_left_y),
    .front_right_x(front_right_x), .front_right_y(front_right_y),
    .rear_right_x(rear_right_x), .rear_right_y(rear_right_y),
    .rear_left_x(rear_left_x), .rear_left_y(rear_left_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arctangent of 2^-i in phase units, 2^32 per turn
  longint atan_turn [ATAN_COUNT] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  string coord_name [8] = '{"front_left_x", "front_left_y", "front_right_x", "front_right_y",
                            "rear_right_x", "rear_right_y", "rear_left_x", "rear_left_y"};

  // register mirror
  logic [30:0] width_q = 31'd65536;
  logic [30:0] length_q = 31'd65536;
  logic        degrees_q = 1'b0;

  pose_t       pose_q [$];
  corner_set_t corner_q [$];

  int          errors = 0;
  int          accepted_n = 0;
  int          checked_n = 0;
  int          settings_n = 1;
  int          burst_left = 1;
  int          gap_left = 0;
  pose_t       next_pose;

  function automatic logic [31:0] place_corner(input longint centre, input longint sum);
    longint v;
    v = centre + ((sum + ROUND_HALF) >>> 31);
    if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
    return v[31:0];
  endfunction

  function automatic corner_set_t predict_corners(input logic signed [31:0] cx,
                                                  input logic signed [31:0] cy,
                                                  input logic signed [31:0] hd);
    logic [63:0]  prod;
    logic [31:0]  phase;
    logic [31:0]  rounded;
    logic [31:0]  rem;
    logic [1:0]   quad;
    longint       x, y, z, xs, ys, cs, sn, fw, sl, fc, fs, sc, ss, ccx, ccy;
    corner_set_t  r;
    prod = {{32{hd[31]}}, hd} * (degrees_q ? PHASE_PER_DEG : PHASE_PER_RAD);
    phase = prod[55:24];
    rounded = phase + 32'h2000_0000;
    quad = rounded[31:30];
    rem = phase - {quad, 30'b0};
    z = $signed(rem);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < rrc_pkg::CORDIC_STAGES && i < ATAN_COUNT; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_turn[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_turn[i];
      end
    end
    case (quad)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    fw = width_q;
    sl = length_q;
    fc = fw * cs;
    fs = fw * sn;
    sc = sl * cs;
    ss = sl * sn;
    ccx = cx;
    ccy = cy;
    r[0] = place_corner(ccx, -fc - ss);
    r[1] = place_corner(ccy, sc - fs);
    r[2] = place_corner(ccx, fc - ss);
    r[3] = place_corner(ccy, sc + fs);
    r[4] = place_corner(ccx, fc + ss);
    r[5] = place_corner(ccy, -sc + fs);
    r[6] = place_corner(ccx, -fc + ss);
    r[7] = place_corner(ccy, -sc - fs);
    return r;
  endfunction

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        corner_q.push_back(predict_corners(center_x, center_y, heading));
        accepted_n++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pose_q.size() > 0) begin
          next_pose = pose_q.pop_front();
          in_valid <= 1'b1;
          center_x <= next_pose.cx;
          center_y <= next_pose.cy;
          heading <= next_pose.hd;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 50;
  logic [31:0] stall_cycle = '0;

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= stall_cycle[2] & stall_cycle[0];
      endcase
    end
  end

  // monitor
  corner_set_t want, got;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = {rear_left_y, rear_left_x, rear_right_y, rear_right_x,
             front_right_y, front_right_x, front_left_y, front_left_x};
      if (corner_q.size() == 0) begin
        $display("%0t unexpected corner set: front_left_x %0d", $time, front_left_x);
        errors++;
      end else begin
        want = corner_q.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (want[k] !== got[k]) begin
            $display("%0t mismatch %s: expected %0d got %0d", $time, coord_name[k],
                     $signed(want[k]), $signed(got[k]));
            errors++;
          end
        end
      end
      checked_n++;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d corner sets outstanding", CYCLE_LIMIT,
             corner_q.size());
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      rrc_pkg::REG_FRONT_WIDTH:   width_q = val;
      rrc_pkg::REG_SIDE_LENGTH:   length_q = val;
      rrc_pkg::REG_ANGLE_DEGREES: degrees_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [30:0] w, input logic [30:0] l, input logic deg);
    write_reg(rrc_pkg::REG_FRONT_WIDTH, w);
    write_reg(rrc_pkg::REG_SIDE_LENGTH, l);
    // upper bits of the flag write carry noise; only bit 0 counts
    write_reg(rrc_pkg::REG_ANGLE_DEGREES,
              {$urandom_range(0, 1) == 1 ? 30'h3FFF_FFFF : 30'h0, deg});
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_n++;
    @(negedge clk);
  endtask

  // let every request through and the pipeline empty before touching registers
  task automatic drain();
    do @(negedge clk);
    while (pose_q.size() != 0 || in_valid || corner_q.size() != 0);
    repeat (DUT_LATENCY + 4) @(negedge clk);
  endtask

  task automatic add_pose(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] hd);
    pose_t p;
    p.cx = cx;
    p.cy = cy;
    p.hd = hd;
    pose_q.push_back(p);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      2: return COORD_MAX - 32'($urandom_range(0, 32'h0100_0000));
      default: return COORD_MIN + 32'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  function automatic logic [31:0] random_heading();
    int t;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        // whole multiples of 45 degrees land on quadrant and octant edges
        t = int'($urandom_range(0, 32)) - 16;
        return 32'(t * 45 * 65536);
      end
      2: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      default: return 32'($urandom_range(0, 1440 * 65536)) - 32'(720 * 65536);
    endcase
  endfunction

  function automatic logic [30:0] random_dim();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return DIM_MAX;
      2: return 31'($urandom_range(0, 32'h0010_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unit square out of reset, radians
    add_pose(32'h0, 32'h0, 32'h0);
    add_pose(COORD_MAX, COORD_MAX, 32'd102944);
    add_pose(COORD_MIN, COORD_MIN, -32'sd205887);
    add_pose(32'd65536, -32'sd65536, COORD_MAX);
    add_pose(-32'sd1, 32'd1, COORD_MIN);
    add_pose(32'h1234_5678, 32'hEDCB_A987, -32'sd1);
    add_pose(32'h0, 32'h0, 32'd1);
    drain();

    // largest rectangle in degrees: saturation and quadrant edges
    set_shape(DIM_MAX, DIM_MAX, 1'b1);
    add_pose(32'h0, 32'h0, 32'h0);
    add_pose(32'h0, 32'h0, 32'(90 * 65536));
    add_pose(COORD_MAX, COORD_MIN, 32'(180 * 65536));
    add_pose(COORD_MIN, COORD_MAX, 32'(270 * 65536));
    add_pose(32'h0, 32'h0, -32'sd5898240);
    add_pose(32'h0, 32'h0, 32'(45 * 65536));
    add_pose(32'h0, 32'h0, -32'sd2949120);
    add_pose(32'd65536, 32'd65536, 32'(390 * 65536));
    add_pose(COORD_MAX, COORD_MAX, COORD_MAX);
    add_pose(COORD_MIN, COORD_MIN, COORD_MIN);
    drain();

    // degenerate rectangle: every corner sits on the centre
    set_shape('0, '0, 1'b0);
    add_pose(COORD_MAX, COORD_MIN, 32'h0);
    add_pose(COORD_MIN, COORD_MAX, COORD_MAX);
    add_pose(32'h8765_4321, 32'h1357_9BDF, 32'd411775);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_shape(random_dim(), random_dim(), ph[0]);
      for (int n = 0; n < PHASE_POSES; n++) add_pose(random_coord(), random_coord(), random_heading());
      drain();
    end

    $display("%0d poses sent through %0d register settings, %0d corner sets checked",
             accepted_n, settings_n, checked_n);
    $display("covered both angle units, zero to full-scale sizes, saturation and stall patterns");
    if (errors == 0 && corner_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d corner sets never arrived", errors, corner_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== rotated_rectangle_corners.f =====
rtl/core/rrc_pkg.sv
rtl/core/rrc_phase.sv
rtl/core/rrc_cordic_cell.sv
rtl/core/rrc_corner.sv
rtl/core/rotated_rectangle_corners.sv
dv/tb_top.sv
